### src/c2p_pkg.sv
`timescale 1ns / 1ps

package c2p_pkg;

    // CORDIC depth
    localparam int ITER_DEFAULT = 16;
    localparam int ITER_MAX     = 24;

    // square root: one result bit per cell
    localparam int SQRT_STEPS = 16;

    localparam int CX_W   = 35;   // x, y scaled by 2^16 plus CORDIC gain
    localparam int Z_W    = 34;   // angle accumulator, radians Q4.30
    localparam int REM_W  = 32;   // x^2 + y^2 and its remainder
    localparam int ROOT_W = 16;
    localparam int DEG_W  = 18;

    localparam logic signed [Z_W-1:0] QUARTER_TURN = 34'sh0_6487_ED51;

    // deg = floor((|z| * 11459 + 100 * 2^22) / (25 * 2^25))
    localparam logic [13:0] DEG_MUL   = 14'd11459;
    localparam logic [45:0] DEG_BIAS  = 46'd419430400;
    localparam int          DEG_SHIFT = 25;
    localparam logic [20:0] RECIP_25  = 21'd1342177;   // floor(2^25 / 25)
    localparam logic [21:0] DIV_25    = 22'd25;

    localparam logic [DEG_W-1:0] FULL_CIRCLE_Q8 = 18'd92160;
    localparam logic [ROOT_W-1:0] RADIUS_MAX    = 16'd46341;

    typedef struct packed {
        logic signed [CX_W-1:0] cx;
        logic signed [CX_W-1:0] cy;
        logic signed [Z_W-1:0]  z;
        logic [REM_W-1:0]       rem;
        logic [ROOT_W-1:0]      root;
        logic                   origin;
    } c2p_stage_t;

    // atan(2^-i) * 2^30, truncated
    function automatic logic [29:0] atan_entry(input int unsigned idx);
        logic [29:0] v;
        case (idx)
            0:       v = 30'h3243F6A8;
            1:       v = 30'h1DAC6705;
            2:       v = 30'h0FADBAFC;
            3:       v = 30'h07F56EA6;
            4:       v = 30'h03FEAB76;
            5:       v = 30'h01FFD55B;
            6:       v = 30'h00FFFAAA;
            7:       v = 30'h007FFF55;
            8:       v = 30'h003FFFEA;
            9:       v = 30'h001FFFFD;
            10:      v = 30'h000FFFFF;
            11:      v = 30'h0007FFFF;
            12:      v = 30'h0003FFFF;
            13:      v = 30'h0001FFFF;
            14:      v = 30'h0000FFFF;
            15:      v = 30'h00007FFF;
            16:      v = 30'h00003FFF;
            17:      v = 30'h00001FFF;
            18:      v = 30'h00000FFF;
            19:      v = 30'h000007FF;
            20:      v = 30'h000003FF;
            21:      v = 30'h000001FF;
            22:      v = 30'h000000FF;
            23:      v = 30'h0000007F;
            default: v = 30'h0;
        endcase
        return v;
    endfunction

endpackage

### src/cartesian_to_polar_degrees.sv
`timescale 1ns / 1ps

// Channel   Dir  Bits  Contents (low bit first)
// s_*       in   32    x_coord[15:0] signed Q8.8, y_coord[31:16] signed Q8.8
// m_*       out  40    radius[15:0] unsigned Q8.8, angle_deg[33:16] signed Q10.8
// cfg_*     in   1     wrap_mode (1: 0..360 deg, 0: -180..180 deg)
//
// One beat in and one beat out per clock when both sides flow.
// A beat passes through a front stage, the cell row
// (one CORDIC micro-rotation and one square-root bit per cell), four stages
// of root rounding and radian-to-degree scaling, and the output register.
// Reset clears every stage valid bit and sets wrap_mode to 1.
// Each stage holds only when its successor is full, so bubbles close up
// and inputs keep flowing while a finished beat waits at the output.

module cartesian_to_polar_degrees #(
    parameter int ITERATIONS = c2p_pkg::ITER_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // x_coord[15:0], y_coord[31:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // radius[15:0], angle_deg[33:16], zero pad
    input  logic        cfg_we,
    input  logic        cfg_wdata
);
    import c2p_pkg::*;

    // CORDIC steps beyond the atan table are not taken
    localparam int NROT  = (ITERATIONS > ITER_MAX) ? ITER_MAX : ITERATIONS;
    // cell row length: long enough for both the rotations and the root bits
    localparam int DEPTH = (NROT > SQRT_STEPS) ? NROT : SQRT_STEPS;

    logic               wrap_mode_reg;

    logic [DEPTH:0]     cv;     // valid into each cell / out of the row
    logic [DEPTH:0]     cr;     // ready into each cell / into the back end
    c2p_stage_t         cd [0:DEPTH];

    logic [15:0]        radius;
    logic [17:0]        angle_deg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrap_mode_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            wrap_mode_reg <= cfg_wdata;
        end
    end

    // quarter-turn fold, squares and their sum
    c2p_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .x_coord   (s_tdata[15:0]),
        .y_coord   (s_tdata[31:16]),
        .out_valid (cv[0]),
        .out_ready (cr[0]),
        .out_data  (cd[0])
    );

    // cell k: micro-rotation k while k < NROT, root bit 15-k while k < 16
    for (genvar k = 0; k < DEPTH; k++)
    begin : g_cell
        c2p_cell #(
            .STEP    (k),
            .ROT_EN  (k < NROT),
            .SQRT_EN (k < SQRT_STEPS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (cv[k]),
            .in_ready  (cr[k]),
            .in_data   (cd[k]),
            .out_valid (cv[k+1]),
            .out_ready (cr[k+1]),
            .out_data  (cd[k+1])
        );
    end

    // root rounding, radians to degrees, wrap, output register
    c2p_deg u_deg (
        .clk       (clk),
        .rst_n     (rst_n),
        .wrap_mode (wrap_mode_reg),
        .in_valid  (cv[DEPTH]),
        .in_ready  (cr[DEPTH]),
        .in_data   (cd[DEPTH]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .radius    (radius),
        .angle_deg (angle_deg)
    );

    assign m_tdata = {6'b0, angle_deg, radius};

    // an empty output register lets the whole row take a beat
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with output register empty");

    // rounded root of at most 2^31
    a_radius_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (radius <= RADIUS_MAX))
        else $error("radius out of range");

    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> (wrap_mode_reg == $past(cfg_wdata)))
        else $error("wrap_mode write lost");

endmodule

### src/c2p_front.sv
`timescale 1ns / 1ps

module c2p_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [15:0]       x_coord,
    input  logic signed [15:0]       y_coord,
    output logic                     out_valid,
    input  logic                     out_ready,
    output c2p_pkg::c2p_stage_t      out_data
);
    import c2p_pkg::*;

    logic                   valid_reg;
    c2p_stage_t             data_reg;
    c2p_stage_t             data_next;
    logic signed [16:0]     xe;
    logic signed [16:0]     ye;
    logic signed [16:0]     cx17;
    logic signed [16:0]     cy17;
    logic signed [31:0]     x_sq;
    logic signed [31:0]     y_sq;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        xe   = 17'(x_coord);
        ye   = 17'(y_coord);
        x_sq = x_coord * x_coord;
        y_sq = y_coord * y_coord;
        data_next.z = '0;
        cx17 = xe;
        cy17 = ye;
        // left half plane: quarter turn toward the right half
        if (x_coord < 0)
        begin
            if (y_coord >= 0)
            begin
                cx17 = ye;
                cy17 = -xe;
                data_next.z = QUARTER_TURN;
            end
            else
            begin
                cx17 = -ye;
                cy17 = xe;
                data_next.z = -QUARTER_TURN;
            end
        end
        data_next.cx     = {{2{cx17[16]}}, cx17, 16'b0};
        data_next.cy     = {{2{cy17[16]}}, cy17, 16'b0};
        data_next.rem    = REM_W'(x_sq) + REM_W'(y_sq);
        data_next.root   = '0;
        data_next.origin = (x_coord == 0) && (y_coord == 0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### src/c2p_cell.sv
`timescale 1ns / 1ps

module c2p_cell #(
    parameter int STEP    = 0,
    parameter bit ROT_EN  = 1'b1,
    parameter bit SQRT_EN = 1'b1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  c2p_pkg::c2p_stage_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output c2p_pkg::c2p_stage_t out_data
);
    import c2p_pkg::*;

    // result bit resolved by this cell
    localparam int SB = SQRT_EN ? (SQRT_STEPS - 1 - STEP) : 0;

    logic                   valid_reg;
    c2p_stage_t             data_reg;
    c2p_stage_t             data_next;
    logic signed [CX_W-1:0] cx_in;
    logic signed [CX_W-1:0] cy_in;
    logic signed [CX_W-1:0] dx;
    logic signed [CX_W-1:0] dy;
    logic signed [Z_W-1:0]  z_step;
    logic [REM_W+1:0]       trial;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        data_next = in_data;
        cx_in  = in_data.cx;
        cy_in  = in_data.cy;
        dx     = cy_in >>> STEP;
        dy     = cx_in >>> STEP;
        z_step = signed'({4'b0, atan_entry(STEP)});
        trial  = ({18'b0, in_data.root} << (SB + 1)) + (34'd1 << (2 * SB));

        if (ROT_EN)
        begin
            if (cy_in >= 0)
            begin
                data_next.cx = cx_in + dx;
                data_next.cy = cy_in - dy;
                data_next.z  = in_data.z + z_step;
            end
            else
            begin
                data_next.cx = cx_in - dx;
                data_next.cy = cy_in + dy;
                data_next.z  = in_data.z - z_step;
            end
        end

        // remainder holds s - root^2
        if (SQRT_EN)
        begin
            if ({2'b0, in_data.rem} >= trial)
            begin
                data_next.rem  = in_data.rem - trial[REM_W-1:0];
                data_next.root = in_data.root | (16'd1 << SB);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### src/c2p_deg.sv
`timescale 1ns / 1ps

module c2p_deg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wrap_mode,
    input  logic                in_valid,
    output logic                in_ready,
    input  c2p_pkg::c2p_stage_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [15:0]         radius,
    output logic [17:0]         angle_deg
);
    import c2p_pkg::*;

    localparam int NST = 5;

    logic [NST-1:0]     v_reg;
    logic [NST-1:0]     en;

    // stage 1: magnitude, sign, rounded radius
    logic [31:0]        a1_reg;
    logic               neg1_reg;
    logic               org1_reg;
    logic [15:0]        rad1_reg;
    // stage 2: scaled angle
    logic [45:0]        p2_reg;
    logic               neg2_reg;
    logic               org2_reg;
    logic [15:0]        rad2_reg;
    // stage 3: quotient estimate
    logic [20:0]        w3_reg;
    logic [16:0]        q03_reg;
    logic               neg3_reg;
    logic               org3_reg;
    logic [15:0]        rad3_reg;
    // stage 4: corrected quotient
    logic [16:0]        q4_reg;
    logic               neg4_reg;
    logic               org4_reg;
    logic [15:0]        rad4_reg;
    // stage 5: output
    logic [15:0]        rad5_reg;
    logic [17:0]        deg5_reg;

    logic [31:0]        a1_next;
    logic [15:0]        rad1_next;
    logic [45:0]        p2_next;
    logic [20:0]        w3_next;
    logic [41:0]        prod3;
    logic [21:0]        r4;
    logic [16:0]        q4_next;
    logic [17:0]        deg5_next;
    logic signed [Z_W-1:0] z_abs;

    always_comb
    begin
        en[NST-1] = !v_reg[NST-1] || out_ready;
        for (int i = NST - 2; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    assign in_ready = en[0];

    always_comb
    begin
        z_abs     = (in_data.z < 0) ? -in_data.z : in_data.z;
        a1_next   = z_abs[31:0];
        rad1_next = in_data.root
                  + 16'({in_data.rem > {16'b0, in_data.root}});
        p2_next   = ({14'b0, a1_reg} * {32'b0, DEG_MUL}) + DEG_BIAS;
        w3_next   = p2_reg[45:DEG_SHIFT];
        prod3     = {21'b0, w3_next} * {21'b0, RECIP_25};
        r4        = {1'b0, w3_reg} - ({5'b0, q03_reg} << 4)
                  - ({5'b0, q03_reg} << 3) - {5'b0, q03_reg};
        q4_next   = q03_reg + 17'({r4 >= DIV_25});
        if (org4_reg)
        begin
            deg5_next = '0;
        end
        else if (neg4_reg && (q4_reg != 0))
        begin
            deg5_next = wrap_mode ? (FULL_CIRCLE_Q8 - {1'b0, q4_reg})
                                  : (18'd0 - {1'b0, q4_reg});
        end
        else
        begin
            deg5_next = {1'b0, q4_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int i = 1; i < NST; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0] && in_valid)
        begin
            a1_reg   <= a1_next;
            neg1_reg <= (in_data.z < 0);
            org1_reg <= in_data.origin;
            rad1_reg <= rad1_next;
        end
        if (en[1] && v_reg[0])
        begin
            p2_reg   <= p2_next;
            neg2_reg <= neg1_reg;
            org2_reg <= org1_reg;
            rad2_reg <= rad1_reg;
        end
        if (en[2] && v_reg[1])
        begin
            w3_reg   <= w3_next;
            q03_reg  <= prod3[41:DEG_SHIFT];
            neg3_reg <= neg2_reg;
            org3_reg <= org2_reg;
            rad3_reg <= rad2_reg;
        end
        if (en[3] && v_reg[2])
        begin
            q4_reg   <= q4_next;
            neg4_reg <= neg3_reg;
            org4_reg <= org3_reg;
            rad4_reg <= rad3_reg;
        end
        if (en[4] && v_reg[3])
        begin
            rad5_reg <= rad4_reg;
            deg5_reg <= deg5_next;
        end
    end

    assign out_valid = v_reg[NST-1];
    assign radius    = rad5_reg;
    assign angle_deg = deg5_reg;

endmodule
